### hw/rtl/dwst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwst_pkg;

  // default table size
  localparam int SLOT_COUNT_DEF = 256;

  // ticks of 100 ns in one millisecond
  localparam logic [13:0] TICKS_PER_MS = 14'd10000;

  // request operations
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // delayed flag as stored in a slot
  localparam logic DELAYED_FLAG = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] routine_tag;
    logic [31:0] context_tag;
    logic        is_delayed;
    logic [31:0] delay_ms;
    logic [62:0] now_time;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] routine_out;
    logic [31:0] context_out;
    logic [8:0]  occupancy;
  } result_t;

  // one table slot as held in memory
  typedef struct packed {
    logic        valid;
    logic        delayed;
    logic [31:0] routine;
    logic [31:0] ctx;
    logic [63:0] due_time;
  } slot_entry_t;

endpackage

`default_nettype wire

### hw/rtl/dwst_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module dwst_slot_mem #(
  parameter int SLOT_COUNT = dwst_pkg::SLOT_COUNT_DEF
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  wire dwst_pkg::slot_entry_t   wr_data,
  input  wire [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output dwst_pkg::slot_entry_t        rd_data
);

  dwst_pkg::slot_entry_t mem [SLOT_COUNT];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/dwst_due_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module dwst_due_calc (
  input  wire         clk,
  input  wire         load,
  input  wire         is_delayed,
  input  wire  [31:0] delay_ms,
  input  wire  [62:0] now_time,
  output logic [63:0] due_time
);

  logic [45:0] ticks;
  logic [62:0] now_r;
  logic        delayed_r;

  // delay in ticks, registered at request accept
  always_ff @(posedge clk) begin
    if (load) begin
      ticks     <= {14'b0, delay_ms} * {32'b0, dwst_pkg::TICKS_PER_MS};
      now_r     <= now_time;
      delayed_r <= is_delayed;
    end
  end

  // immediate items keep a zero due time
  assign due_time = delayed_r ? ({1'b0, now_r} + {18'b0, ticks}) : 64'd0;

endmodule

`default_nettype wire

### hw/rtl/delayed_work_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Delayed work slot table.
// A request is taken on start while busy is low. Enqueue stores a routine tag,
// context tag and optional due time (now_time + delay_ms * 10000) in the lowest
// free slot; dequeue takes and frees the lowest slot that is immediate or due.
// Each request gives one result on the result port, marked by a one-cycle done
// strobe; the receiver cannot stall, so results are never held back.
// An enqueue with a zero routine tag answers in the next cycle and leaves busy
// low. Other requests scan the slot memory one entry per cycle, starting at slot
// 0, and stop at the first match or after the last slot; busy is high until
// the result is out. The scan rate is set by the single read port of the
// slot memory.
// Reset: a clearing pass writes every slot empty; busy is high during the
// pass and no request is taken.
// slot_index reports the slot number modulo 256, occupancy modulo 512.
module delayed_work_slot_table #(
  parameter int SLOT_COUNT = dwst_pkg::SLOT_COUNT_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  wire dwst_pkg::request_t request,
  output logic                    done,
  output dwst_pkg::result_t       result
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0]            state;
  logic [IDX_W-1:0]      clr_idx;
  logic [IDX_W-1:0]      chk_idx;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  dwst_pkg::request_t    req;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  dwst_pkg::slot_entry_t wr_data;
  logic [IDX_W-1:0]      rd_addr;
  dwst_pkg::slot_entry_t rd_data;
  logic [63:0]           due_time;

  logic                  is_deq;
  logic                  slot_ready;
  logic                  hit;
  logic                  accept;
  logic [IDX_W+7:0]      idx_ext;
  logic [CNT_W+8:0]      occ_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  dwst_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  dwst_due_calc u_due (
    .clk       (clk),
    .load      (accept),
    .is_delayed(request.is_delayed),
    .delay_ms  (request.delay_ms),
    .now_time  (request.now_time),
    .due_time  (due_time)
  );

  // match test on the slot read in the previous cycle
  assign is_deq     = (req.operation == dwst_pkg::OP_DEQUEUE);
  assign slot_ready = rd_data.valid &&
                      (!rd_data.delayed || ({1'b0, req.now_time} >= rd_data.due_time));
  assign hit        = is_deq ? slot_ready : !rd_data.valid;

  // reported index and occupancy, cut to the result widths
  assign idx_ext = {8'b0, chk_idx};
  assign occ_ext = {9'b0, count_next};

  // read address runs one slot ahead of the check
  always_comb begin
    rd_addr = '0;
    if (state == S_SCAN) begin
      rd_addr = chk_idx + 1'b1;
    end
  end

  // write port: clearing pass, or update of the matched slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (state == S_SCAN && hit) begin
      wr_en = 1'b1;
      if (is_deq) begin
        wr_data       = rd_data;
        wr_data.valid = 1'b0;
      end else begin
        wr_data.valid    = 1'b1;
        wr_data.delayed  = req.is_delayed ? dwst_pkg::DELAYED_FLAG : 1'b0;
        wr_data.routine  = req.routine_tag;
        wr_data.ctx      = req.context_tag;
        wr_data.due_time = due_time;
      end
    end
  end

  // occupancy after the current request
  always_comb begin
    count_next = count;
    if (state == S_SCAN && hit) begin
      if (!is_deq) begin
        count_next = count + 1'b1;
      end else if (count != '0) begin
        count_next = count - 1'b1;
      end
    end
  end

  // request sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req <= request;
            if (request.operation == dwst_pkg::OP_ENQUEUE && request.routine_tag == 32'd0) begin
              done   <= 1'b1;
              result <= '{status: dwst_pkg::ST_INVALID, slot_index: 8'd0,
                          routine_out: 32'd0, context_out: 32'd0,
                          occupancy: occ_ext[8:0]};
            end else begin
              state   <= S_SCAN;
              chk_idx <= '0;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            done   <= 1'b1;
            state  <= S_IDLE;
            result <= '{status: dwst_pkg::ST_OK, slot_index: idx_ext[7:0],
                        routine_out: is_deq ? rd_data.routine : 32'd0,
                        context_out: is_deq ? rd_data.ctx : 32'd0,
                        occupancy: occ_ext[8:0]};
          end else if (chk_idx == LAST_IDX) begin
            done   <= 1'b1;
            state  <= S_IDLE;
            result <= '{status: is_deq ? dwst_pkg::ST_NONE : dwst_pkg::ST_FULL,
                        slot_index: 8'd0, routine_out: 32'd0, context_out: 32'd0,
                        occupancy: occ_ext[8:0]};
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // reset starts the clearing pass, which blocks requests
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // occupancy never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOT_COUNT))
    else $error("occupied count beyond table size");

  // full is reported only when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == dwst_pkg::ST_FULL |-> count == CNT_W'(SLOT_COUNT))
    else $error("table full reported with free slots");

  // no result strobe during the clearing pass
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !done)
    else $error("result during clearing pass");
`endif

endmodule

`default_nettype wire

### dv/tb_delayed_work_slot_table.sv
`timescale 1ns / 1ps

module tb_delayed_work_slot_table;
  import dwst_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [62:0] NOW_MAX = '1;
  // due time of an item enqueued here with the longest delay lands exactly on NOW_MAX
  localparam logic [62:0] NOW_FAR = NOW_MAX - 63'(64'hFFFF_FFFF * 64'd10000);

  // table model and store of predicted results
  class slot_table_scoreboard;
    bit          slot_used    [SLOTS];
    bit          slot_delayed [SLOTS];
    logic [31:0] slot_routine [SLOTS];
    logic [31:0] slot_context [SLOTS];
    logic [63:0] slot_due     [SLOTS];
    int unsigned used_count;
    result_t     expected_results[$];
    int          failures;

    function new();
      used_count = 0;
      failures   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // apply one request to the table and return its result
    function result_t predict_result(request_t r);
      result_t res;
      bit      found;
      found = 1'b0;
      res   = '0;
      if (r.operation == OP_ENQUEUE) begin
        if (r.routine_tag == 32'd0) begin
          res.status = ST_INVALID;
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (!slot_used[i]) begin
              found           = 1'b1;
              slot_used[i]    = 1'b1;
              slot_delayed[i] = r.is_delayed;
              slot_routine[i] = r.routine_tag;
              slot_context[i] = r.context_tag;
              slot_due[i]     = r.is_delayed ?
                                {1'b0, r.now_time} + 64'(r.delay_ms) * 64'(TICKS_PER_MS) : 64'd0;
              used_count++;
              res.status      = ST_OK;
              res.slot_index  = 8'(i);
            end
          end
        end
      end else begin
        res.status = ST_NONE;
        for (int i = 0; i < SLOTS && !found; i++) begin
          // immediate items are always ready, delayed ones once due
          if (slot_used[i] && !(slot_delayed[i] && {1'b0, r.now_time} < slot_due[i])) begin
            found           = 1'b1;
            slot_used[i]    = 1'b0;
            if (used_count > 0) used_count--;
            res.status      = ST_OK;
            res.slot_index  = 8'(i);
            res.routine_out = slot_routine[i];
            res.context_out = slot_context[i];
          end
        end
      end
      res.occupancy = 9'(used_count);
      return res;
    endfunction

    function void note_request(request_t r);
      expected_results.push_back(predict_result(r));
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with no request waiting, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
        check_field("routine_out", 64'(want.routine_out), 64'(got.routine_out));
        check_field("context_out", 64'(want.context_out), 64'(got.context_out));
        check_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;

  slot_table_scoreboard table_sb;
  logic [62:0] now_ticks;
  bit          gaps_on;

  delayed_work_slot_table DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  // watch both sides of the block
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) table_sb.check_result(result);
      if (start && busy === 1'b0) table_sb.note_request(request);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("delayed_work_slot_table verification failed");
    $finish;
  end

  function automatic request_t make_request(logic op, logic [31:0] routine, logic [31:0] ctx,
                                            logic delayed, logic [31:0] delay,
                                            logic [62:0] now);
    request_t r;
    r.operation   = op;
    r.routine_tag = routine;
    r.context_tag = ctx;
    r.is_delayed  = delayed;
    r.delay_ms    = delay;
    r.now_time    = now;
    return r;
  endfunction

  // random request on a mostly advancing timeline, with some arbitrary times
  function automatic request_t random_request(int enq_pct);
    request_t r;
    int       pick;
    r.operation   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
    r.routine_tag = ($urandom_range(0, 99) < 4) ? 32'd0 : $urandom;
    r.context_tag = $urandom;
    r.is_delayed  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) r.delay_ms = $urandom_range(0, 30);
    else if (pick < 8) r.delay_ms = $urandom_range(0, 1000);
    else r.delay_ms = $urandom;
    now_ticks = now_ticks + 63'($urandom_range(0, 30000));
    pick = $urandom_range(0, 99);
    if (pick < 8) r.now_time = 63'({$urandom, $urandom});
    else if (pick < 10) r.now_time = NOW_MAX;
    else r.now_time = now_ticks;
    return r;
  endfunction

  // hold a request on the port until the block takes it
  task automatic send_request(request_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= r;
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
  endtask

  // sender pauses until every result is back
  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (table_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int count, int enq_pct);
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (count) send_request(random_request(enq_pct));
    wait_for_results();
  endtask

  // enqueue until the table is full, then push past full
  task automatic fill_table();
    request_t r;
    gaps_on = 1'b1;
    while (table_sb.used_count < SLOTS) send_request(random_request(100));
    repeat (3) begin
      r = random_request(100);
      r.routine_tag[0] = 1'b1;
      send_request(r);
    end
    wait_for_results();
  endtask

  initial begin
    table_sb  = new();
    now_ticks = 63'($urandom) << 8;
    gaps_on   = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, bad routine, extremes of fields and due times
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, '0));
    send_request(make_request(OP_ENQUEUE, '0, '1, 1'b1, '1, NOW_MAX));
    send_request(make_request(OP_ENQUEUE, '1, '1, 1'b0, '1, NOW_MAX));
    send_request(make_request(OP_ENQUEUE, 32'd1, '0, 1'b1, '0, '0));
    send_request(make_request(OP_ENQUEUE, 32'h8000_0000, 32'h5A5A_A5A5, 1'b1, '1, NOW_FAR));
    send_request(make_request(OP_ENQUEUE, 32'd2, 32'd3, 1'b1, 32'd5, 63'd1000));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, '0));
    send_request(make_request(OP_DEQUEUE, '1, '1, 1'b1, '1, '0));
    // one tick before the due time, then exactly on it
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, 63'd50999));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, 63'd51000));
    // freed low slots are reused before higher ones
    send_request(make_request(OP_ENQUEUE, 32'h1234_5678, '1, 1'b0, '0, '0));
    send_request(make_request(OP_ENQUEUE, 32'hFFFF_FFFE, 32'h1, 1'b1, 32'd1, '0));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, NOW_MAX - 63'd1));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, NOW_MAX - 63'd1));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, NOW_MAX - 63'd1));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, NOW_MAX));
    send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0, '0, NOW_MAX));
    send_request(make_request(OP_ENQUEUE, '0, '0, 1'b0, '0, '0));
    wait_for_results();

    // random: mixed phases, a fill to full, then a drain
    repeat (4) begin
      case ($urandom_range(0, 2))
        0: run_phase(50, 80);
        1: run_phase(50, 50);
        default: run_phase(50, 20);
      endcase
    end
    fill_table();
    run_phase(100, 15);
    run_phase(50, 60);
    run_phase(50, 40);

    // let any late result show up
    repeat (SLOTS + 10) @(negedge clk);
    if (table_sb.failures == 0 && table_sb.pending() == 0) begin
      $display("delayed_work_slot_table verification clean");
    end else begin
      $display("delayed_work_slot_table verification failed");
    end
    $finish;
  end

endmodule
